// ===== rtl/lwts_pkg.sv =====
// Package for the longest-window-with-target-sum block.
// Holds field widths, item structs and the sequencer state type; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lwts_pkg;

  localparam int VALUE_W              = 16;
  localparam int TARGET_W             = 24;
  localparam int SUM_W                = 26;
  localparam int LEN_W                = 11;
  localparam int DEFAULT_WINDOW_DEPTH = 1024;
  localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(1);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } lwts_in_t;

  typedef struct packed {
    logic             found;
    logic [LEN_W-1:0] best_length;
    logic             overflow;
  } lwts_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVICT,
    S_CHECK,
    S_DROP,
    S_FINISH
  } lwts_state_t;

endpackage

`default_nettype wire

// ===== rtl/longest_window_with_target_sum.sv =====
// Per item: accept and push, then check; each front drop adds a head read, then a
// subtract; a full window adds an eviction step; the last item also loads the result
// register, and waits while an earlier result still waits there. One item in flight:
// a new item is not accepted until the current one is through.
// The sequencer spends one state per memory access (one write port, one registered read).
// Reset (synchronous, rst_n low) clears pointers, count, sum, flags and target_sum=1.
// The window memory is not cleared: every entry is written before it is read.
// Top level: window memory, pointers, running sum and the drop sequencer.
// Depends on lwts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module longest_window_with_target_sum
  import lwts_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input items
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire lwts_in_t            in_data,
  // result items
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      lwts_out_t           out_data,
  // target_sum register
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire logic [TARGET_W-1:0] cfg_data
);

  localparam int PTR_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_DEPTH);

  // Window memory: circular buffer, one write and one registered read per cycle.
  logic [VALUE_W-1:0] mem [WINDOW_DEPTH];
  logic [VALUE_W-1:0] rd_data_r;
  logic               mem_we;
  logic               mem_re;

  lwts_state_t        state_r, state_nxt;
  logic [TARGET_W-1:0] target_r, target_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [CNT_W-1:0]   best_r, best_nxt;
  logic               match_r, match_nxt;
  logic               ovf_r, ovf_nxt;
  // The accepted item, held while the window settles.
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic               last_r, last_nxt;
  // Output register: decouples the result from the consumer.
  logic               out_valid_r, out_valid_nxt;
  lwts_out_t          out_r, out_nxt;

  logic               in_fire;
  logic               out_free;
  logic [SUM_W-1:0]   target_ext;
  logic [PTR_W-1:0]   head_inc;
  logic [PTR_W-1:0]   tail_inc;

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign out_free   = !out_valid_r || out_ready;
  assign target_ext = SUM_W'(target_r);
  assign head_inc   = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
  assign tail_inc   = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_r] <= val_nxt;
    end
    if (mem_re) begin
      rd_data_r <= mem[head_r];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    target_nxt    = target_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    best_nxt      = best_r;
    match_nxt     = match_r;
    ovf_nxt       = ovf_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_valid) begin
      target_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          val_nxt  = in_data.value;
          last_nxt = in_data.last;
          if (cnt_r == CNT_FULL) begin
            // Full window: read the oldest entry, evict it next cycle.
            ovf_nxt   = 1'b1;
            mem_re    = 1'b1;
            state_nxt = S_EVICT;
          end else begin
            mem_we    = 1'b1;
            tail_nxt  = tail_inc;
            cnt_nxt   = cnt_r + CNT_W'(1);
            sum_nxt   = sum_r + SUM_W'(in_data.value);
            state_nxt = S_CHECK;
          end
        end
      end
      S_EVICT: begin
        // Evict and push together; head == tail here, old data already read.
        mem_we    = 1'b1;
        head_nxt  = head_inc;
        tail_nxt  = tail_inc;
        sum_nxt   = sum_r - SUM_W'(rd_data_r) + SUM_W'(val_r);
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sum_r > target_ext && cnt_r != '0) begin
          mem_re    = 1'b1;
          state_nxt = S_DROP;
        end else begin
          if (cnt_r != '0 && sum_r == target_ext) begin
            match_nxt = 1'b1;
            if (cnt_r > best_r) begin
              best_nxt = cnt_r;
            end
          end
          state_nxt = last_r ? S_FINISH : S_IDLE;
        end
      end
      S_DROP: begin
        sum_nxt   = sum_r - SUM_W'(rd_data_r);
        head_nxt  = head_inc;
        cnt_nxt   = cnt_r - CNT_W'(1);
        state_nxt = S_CHECK;
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.found       = match_r;
          out_nxt.best_length = LEN_W'(best_r);
          out_nxt.overflow    = ovf_r;
          // Start the next sequence from an empty window.
          head_nxt  = '0;
          tail_nxt  = '0;
          cnt_nxt   = '0;
          sum_nxt   = '0;
          best_nxt  = '0;
          match_nxt = 1'b0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      target_r    <= TARGET_RESET;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      best_r      <= '0;
      match_r     <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      target_r    <= target_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      best_r      <= best_nxt;
      match_r     <= match_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    last_r <= last_nxt;
    out_r  <= out_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("window count beyond depth");

  a_drop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DROP |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("front drop did not shrink the window");

  a_finish_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_free) |=> (out_valid_r && cnt_r == '0 && sum_r == '0))
    else $error("result load did not clear the sequence");

  a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
    best_r <= CNT_FULL)
    else $error("best length beyond depth");
`endif

endmodule

`default_nettype wire
